// ===== hdl/atm_pkg.sv =====
// shared types and constants for the alarm table time matcher
// used by atm_ctrl, atm_datapath and alarm_table_time_matcher_top; no dependencies
`default_nettype none

package atm_pkg;

    // tuser codes: what an input transaction carries
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // day codes and special bytes
    localparam logic [7:0] DAY_WEEK  = 8'h07;
    localparam logic [7:0] DAY_ALL   = 8'h08;
    localparam logic [7:0] DAY_OFF   = 8'h09;
    localparam logic [7:0] DAY_LAST  = 8'h06;
    localparam logic [7:0] WILDCARD  = 8'h60;
    localparam logic [7:0] RAW_BLANK = 8'hff;
    localparam logic [7:0] CHAN_DFLT = 8'h01;
    localparam logic [7:0] TIME_DFLT = 8'h00;

    // field widths
    localparam int IDX_W    = 5;
    localparam int MASK_W   = 9;
    localparam int CHANNELS = 9;

    // one stored alarm entry
    typedef struct packed {
        logic [7:0] channel;
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
    } entry_t;

    // controller state
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_FINISH
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic write;       // store the entry of the accepted transaction
        logic tick_start;  // latch tick time, clear scan address and mask
        logic scan_en;     // read one table entry, advance address
        logic load_out;    // move the mask into the output register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic scan_last;   // address points at the last entry
        logic out_free;    // output register empty or being taken
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/atm_ctrl.sv =====
// controller state machine for the alarm table time matcher
// depends on atm_pkg
`default_nettype none

module atm_ctrl
    import atm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    input  wire logic    s_tuser,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == FUNC_WRITE)
                    begin
                        cmd.write  = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.tick_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                // last entry read is folded into the mask here
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/atm_datapath.sv =====
// datapath: alarm table memory, scan address, match logic, mask and output register
// depends on atm_pkg
`default_nettype none

module atm_datapath
    import atm_pkg::*;
#(
    parameter int ENTRIES = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    output status_t                status,
    input  wire logic [IDX_W-1:0]  entry_index,
    input  wire logic [7:0]        day_code,
    input  wire logic [7:0]        hour_bcd,
    input  wire logic [7:0]        minute_bcd,
    input  wire logic [7:0]        second_bcd,
    input  wire logic [7:0]        out_channel,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [MASK_W-1:0]      fired_mask
);

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WIDE_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;

    entry_t              mem [ENTRIES];
    logic [ENTRIES-1:0]  valid_reg;
    entry_t              rd_entry_reg;
    logic                rd_valid_reg;
    logic                rd_pend_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [7:0]          tday_reg;
    logic [7:0]          thour_reg;
    logic [7:0]          tmin_reg;
    logic [7:0]          tsec_reg;
    logic [MASK_W-1:0]   acc_reg;
    logic [MASK_W-1:0]   acc_next;
    logic                out_valid_reg;
    logic [MASK_W-1:0]   out_mask_reg;

    logic [WIDE_W-1:0]   idx_wide;
    logic [ADDR_W-1:0]   wr_addr;
    logic                wr_en;
    entry_t              wr_entry;
    logic                day_ok;
    logic                time_ok;
    logic                he;
    logic                me;
    logic                se;
    logic [MASK_W-1:0]   hit;

    // write address and range check
    assign idx_wide = WIDE_W'(entry_index);
    assign wr_addr  = idx_wide[ADDR_W-1:0];
    assign wr_en    = cmd.write && (32'(idx_wide) < 32'(ENTRIES));

    // blank bytes replaced by defaults
    always_comb
    begin
        wr_entry.day     = (day_code    == RAW_BLANK) ? DAY_OFF   : day_code;
        wr_entry.hour    = (hour_bcd    == RAW_BLANK) ? TIME_DFLT : hour_bcd;
        wr_entry.minute  = (minute_bcd  == RAW_BLANK) ? TIME_DFLT : minute_bcd;
        wr_entry.second  = (second_bcd  == RAW_BLANK) ? TIME_DFLT : second_bcd;
        wr_entry.channel = (out_channel == RAW_BLANK) ? CHAN_DFLT : out_channel;
    end

    // table memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (cmd.scan_en)
        begin
            rd_entry_reg <= mem[addr_reg];
            rd_valid_reg <= valid_reg[addr_reg];
        end
    end

    // per-entry valid flags, an unwritten entry reads as off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // tick time capture
    always_ff @(posedge clk)
    begin
        if (cmd.tick_start)
        begin
            tday_reg  <= day_code;
            thour_reg <= hour_bcd;
            tmin_reg  <= minute_bcd;
            tsec_reg  <= second_bcd;
        end
    end

    // day match of the entry just read
    always_comb
    begin
        case (rd_entry_reg.day)
            DAY_WEEK: day_ok = (tday_reg <= DAY_LAST);
            DAY_ALL:  day_ok = 1'b1;
            DAY_OFF:  day_ok = 1'b0;
            default:  day_ok = (rd_entry_reg.day == tday_reg);
        endcase
    end

    // time match with one wildcard field allowed
    always_comb
    begin
        he      = (rd_entry_reg.hour   == thour_reg);
        me      = (rd_entry_reg.minute == tmin_reg);
        se      = (rd_entry_reg.second == tsec_reg);
        time_ok = (he && me && se)
               || ((rd_entry_reg.hour   == WILDCARD) && me && se)
               || ((rd_entry_reg.minute == WILDCARD) && he && se)
               || ((rd_entry_reg.second == WILDCARD) && he && me);
    end

    // channel decode, channels past the mask are dropped
    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            hit[i] = (rd_entry_reg.channel == 8'(i)) && (i < CHANNELS);
        end
        acc_next = acc_reg;
        if (rd_pend_reg && rd_valid_reg && day_ok && time_ok)
        begin
            acc_next = acc_reg | hit;
        end
    end

    // scan address, read pipeline flag and mask accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg    <= '0;
            rd_pend_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            rd_pend_reg <= cmd.scan_en;
            if (cmd.tick_start || cmd.write)
            begin
                addr_reg <= '0;
                acc_reg  <= '0;
            end
            else
            begin
                acc_reg <= acc_next;
                if (cmd.scan_en)
                begin
                    addr_reg <= addr_reg + 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_mask_reg <= acc_reg;
        end
    end

    assign status.scan_last = (addr_reg == ADDR_W'(ENTRIES - 1));
    assign status.out_free  = !out_valid_reg || m_tready;
    assign m_tvalid         = out_valid_reg;
    assign fired_mask       = out_mask_reg;

endmodule

`default_nettype wire

// ===== hdl/alarm_table_time_matcher_top.sv =====
// alarm table time matcher: a write loads one entry, a tick returns the fired channel mask
// tick: the fired mask comes from a scan of the table through its single read port,
// one entry a cycle, and is loaded into the output register once that is free
// write: the result is a zero mask, loaded into the output register the same way
// reset: rst_n asynchronous active low; all entries read as off through per-entry valid
// flags cleared at reset, no clearing pass; depends on atm_pkg, atm_ctrl, atm_datapath
`default_nettype none

module alarm_table_time_matcher_top
    import atm_pkg::*;
#(
    parameter int ENTRIES = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // entry_index[4:0], day_code[12:5], hour_bcd[20:13], minute_bcd[28:21],
    // second_bcd[36:29], out_channel[44:37], zero pad[47:45]
    input  wire logic [47:0] s_tdata,
    // func[0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // fired_mask[8:0], zero pad[15:9]
    output logic [15:0]      m_tdata
);

    cmd_t              cmd;
    status_t           status;
    logic [MASK_W-1:0] fired_mask;

    // controller
    atm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    atm_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .entry_index (s_tdata[4:0]),
        .day_code    (s_tdata[12:5]),
        .hour_bcd    (s_tdata[20:13]),
        .minute_bcd  (s_tdata[28:21]),
        .second_bcd  (s_tdata[36:29]),
        .out_channel (s_tdata[44:37]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .fired_mask  (fired_mask)
    );

    assign m_tdata = {{(16 - MASK_W){1'b0}}, fired_mask};

`ifndef SYNTHESIS
    // no new transaction taken while the table is being scanned
    a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_en |-> !s_tready)
        else $error("input accepted during table scan");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("output register loaded while result pending");

    // a result appears only after an output load command
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.load_out))
        else $error("result valid without output load");
`endif

endmodule

`default_nettype wire

// ===== verif/alarm_table_time_matcher_checker.sv =====
// checker for alarm_table_time_matcher_top: watches both stream channels, keeps its own
// copy of the alarm table, predicts the fired mask of every input transaction and compares
// depends on atm_pkg
module alarm_table_time_matcher_checker
    import atm_pkg::*;
#(
    parameter int ENTRIES = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // entry_index[4:0], day_code[12:5], hour_bcd[20:13], minute_bcd[28:21],
    // second_bcd[36:29], out_channel[44:37], zero pad[47:45]
    input  wire logic [47:0] s_tdata,
    // func[0]
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    // fired_mask[8:0], zero pad[15:9]
    input  wire logic [15:0] m_tdata,
    output int               fail_count,
    output int               pending
);

    entry_t            alarm_copy [ENTRIES];
    logic [MASK_W-1:0] expected_masks [$];

    // a raw byte of 0xff stands for the field's default
    function automatic logic [7:0] or_blank(input logic [7:0] raw, input logic [7:0] dflt);
        return (raw == RAW_BLANK) ? dflt : raw;
    endfunction

    // scan the whole table against one tick
    function automatic logic [MASK_W-1:0] fired_for_tick(input logic [7:0] d,
                                                         input logic [7:0] h,
                                                         input logic [7:0] m,
                                                         input logic [7:0] s);
        logic [MASK_W-1:0] mask;
        logic              day_hit;
        logic              time_hit;
        logic              he;
        logic              me;
        logic              se;
        mask = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            case (alarm_copy[i].day)
                DAY_WEEK: day_hit = (d <= DAY_LAST);
                DAY_ALL:  day_hit = 1'b1;
                DAY_OFF:  day_hit = 1'b0;
                default:  day_hit = (alarm_copy[i].day == d);
            endcase
            he = (alarm_copy[i].hour == h);
            me = (alarm_copy[i].minute == m);
            se = (alarm_copy[i].second == s);
            // all equal, or one stored field is the wildcard and the other two are equal
            time_hit = (he && me && se)
                    || (alarm_copy[i].hour == WILDCARD && me && se)
                    || (he && alarm_copy[i].minute == WILDCARD && se)
                    || (he && me && alarm_copy[i].second == WILDCARD);
            if (day_hit && time_hit && alarm_copy[i].channel < CHANNELS)
                mask[alarm_copy[i].channel[3:0]] = 1'b1;
        end
        return mask;
    endfunction

    // result side first, since a result never belongs to the transaction of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        logic [MASK_W-1:0] want;
        logic [4:0]        idx;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                alarm_copy[i].day     = DAY_OFF;
                alarm_copy[i].hour    = TIME_DFLT;
                alarm_copy[i].minute  = TIME_DFLT;
                alarm_copy[i].second  = TIME_DFLT;
                alarm_copy[i].channel = CHAN_DFLT;
            end
            expected_masks.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // compare an output transaction with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (expected_masks.size() == 0)
                begin
                    $error("fired_mask: no result expected, actual %h", m_tdata[MASK_W-1:0]);
                    fail_count++;
                end
                else
                begin
                    want = expected_masks.pop_front();
                    if (m_tdata[MASK_W-1:0] !== want)
                    begin
                        $error("fired_mask: expected %h actual %h",
                               want, m_tdata[MASK_W-1:0]);
                        fail_count++;
                    end
                end
            end
            // predict an input transaction
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == FUNC_WRITE)
                begin
                    idx = s_tdata[4:0];
                    if (idx < ENTRIES)
                    begin
                        alarm_copy[idx].day     = or_blank(s_tdata[12:5], DAY_OFF);
                        alarm_copy[idx].hour    = or_blank(s_tdata[20:13], TIME_DFLT);
                        alarm_copy[idx].minute  = or_blank(s_tdata[28:21], TIME_DFLT);
                        alarm_copy[idx].second  = or_blank(s_tdata[36:29], TIME_DFLT);
                        alarm_copy[idx].channel = or_blank(s_tdata[44:37], CHAN_DFLT);
                    end
                    expected_masks.push_back('0);
                end
                else
                begin
                    expected_masks.push_back(fired_for_tick(s_tdata[12:5], s_tdata[20:13],
                                                            s_tdata[28:21], s_tdata[36:29]));
                end
            end
            pending = expected_masks.size();
        end
    end

endmodule

// ===== verif/alarm_table_time_matcher_top_tb.sv =====
// testbench top for alarm_table_time_matcher_top: directed and random alarm writes and
// ticks with random idling on both channels; depends on atm_pkg and the checker module
module alarm_table_time_matcher_top_tb;
    import atm_pkg::*;

    localparam int          ENTRIES     = 32;
    localparam int          STALL_LIMIT = 4000;
    // common bcd values so random ticks hit random entries
    localparam logic [39:0] BCD_POOL    = {8'h59, 8'h23, 8'h12, 8'h09, 8'h00};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        s_tuser  = FUNC_WRITE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    logic        idle_on  = 1'b1;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    int          fail_count;
    int          pending;
    logic [23:0] planted_time [ENTRIES];

    alarm_table_time_matcher_top #(.ENTRIES(ENTRIES)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    alarm_table_time_matcher_checker #(.ENTRIES(ENTRIES)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: stalls in random bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("alarm_table_time_matcher_top test failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one transaction, then maybe a sender gap while idling is on
    task automatic send_item(input logic func, input logic [47:0] data);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_entry(input logic [4:0] idx, input logic [7:0] d, input logic [7:0] h,
                               input logic [7:0] m, input logic [7:0] s, input logic [7:0] ch);
        planted_time[idx] = {h, m, s};
        send_item(FUNC_WRITE, {3'b000, ch, s, m, h, d, idx});
    endtask

    // index and channel are ignored on a tick, so they carry noise
    task automatic send_tick(input logic [7:0] d, input logic [7:0] h,
                             input logic [7:0] m, input logic [7:0] s);
        send_item(FUNC_TICK, {3'b000, 8'($urandom), s, m, h, d, 5'($urandom)});
    endtask

    function automatic logic [7:0] rand_time_byte();
        int k;
        k = $urandom_range(0, 4);
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: return BCD_POOL[8*k +: 8];
            8, 9, 10:               return WILDCARD;
            11:                     return RAW_BLANK;
            default:                return 8'($urandom);
        endcase
    endfunction

    // tick field aimed at a planted entry: blank was stored as zero, wildcard mostly replaced
    function automatic logic [7:0] tick_field_from(input logic [7:0] raw);
        if (raw == RAW_BLANK)
            return TIME_DFLT;
        if (raw == WILDCARD && $urandom_range(0, 3) != 0)
            return rand_time_byte();
        return raw;
    endfunction

    // random writes and ticks, then a pause until every result has come
    task automatic run_phase(input int count, input logic idle);
        logic [4:0]  idx;
        logic [7:0]  d;
        logic [7:0]  h;
        logic [7:0]  m;
        logic [7:0]  s;
        logic [7:0]  ch;
        logic [23:0] base;
        idle_on <= idle;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 35)
            begin
                idx = 5'($urandom);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: d = 8'($urandom_range(0, 9));
                    6:                d = RAW_BLANK;
                    default:          d = 8'($urandom);
                endcase
                h = rand_time_byte();
                m = rand_time_byte();
                s = rand_time_byte();
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: ch = 8'($urandom_range(0, CHANNELS - 1));
                    7:                   ch = 8'(CHANNELS);
                    8:                   ch = RAW_BLANK;
                    default:             ch = 8'($urandom);
                endcase
                write_entry(idx, d, h, m, s, ch);
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6, 7: d = 8'($urandom_range(0, DAY_LAST));
                    8:                      d = 8'($urandom_range(DAY_WEEK, DAY_OFF));
                    default:                d = 8'($urandom);
                endcase
                if ($urandom_range(0, 9) < 6)
                begin
                    base = planted_time[$urandom_range(0, ENTRIES - 1)];
                    h = tick_field_from(base[23:16]);
                    m = tick_field_from(base[15:8]);
                    s = tick_field_from(base[7:0]);
                end
                else
                begin
                    h = rand_time_byte();
                    m = rand_time_byte();
                    s = rand_time_byte();
                end
                send_tick(d, h, m, s);
            end
        end
        // hold off until the block has drained
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // stimulus and verdict
    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
            planted_time[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset table, defaults, day codes, wildcards, ignored channels
        send_tick(8'h03, 8'h00, 8'h00, 8'h00);
        write_entry(5'd0, DAY_ALL, 8'h12, 8'h30, 8'h00, 8'h00);
        send_tick(8'h03, 8'h12, 8'h30, 8'h00);
        write_entry(5'd31, RAW_BLANK, RAW_BLANK, RAW_BLANK, RAW_BLANK, RAW_BLANK);
        send_tick(8'h00, 8'h00, 8'h00, 8'h00);
        write_entry(5'd31, DAY_ALL, RAW_BLANK, RAW_BLANK, RAW_BLANK, RAW_BLANK);
        send_tick(DAY_LAST, 8'h00, 8'h00, 8'h00);
        write_entry(5'd1, DAY_WEEK, WILDCARD, 8'h15, 8'h45, 8'h08);
        send_tick(DAY_LAST, 8'h23, 8'h15, 8'h45);
        send_tick(DAY_WEEK, 8'h23, 8'h15, 8'h45);
        write_entry(5'd2, 8'h05, 8'h08, WILDCARD, 8'h00, 8'(CHANNELS));
        send_tick(8'h05, 8'h08, 8'h42, 8'h00);
        write_entry(5'd3, 8'h00, 8'h10, 8'h20, WILDCARD, 8'h04);
        send_tick(8'h00, 8'h10, 8'h20, 8'h59);
        // two wildcards: only a literal match of one of them hits
        write_entry(5'd4, DAY_ALL, WILDCARD, WILDCARD, 8'h30, 8'h02);
        send_tick(8'h01, 8'h11, 8'h22, 8'h30);
        send_tick(8'h01, 8'h11, WILDCARD, 8'h30);
        // out-of-range day code stored as given
        write_entry(5'd5, 8'hfe, 8'h59, 8'h59, 8'h59, 8'h03);
        send_tick(8'hfe, 8'h59, 8'h59, 8'h59);
        send_tick(RAW_BLANK, RAW_BLANK, RAW_BLANK, RAW_BLANK);
        write_entry(5'd6, DAY_OFF, 8'h00, 8'h00, 8'h00, 8'h05);
        send_tick(8'h02, 8'h00, 8'h00, 8'h00);
        write_entry(5'd0, DAY_ALL, 8'h12, 8'h30, 8'h00, 8'h80);
        send_tick(8'h03, 8'h12, 8'h30, 8'h00);
        write_entry(5'd7, 8'h03, 8'h01, 8'h02, 8'h03, 8'h07);
        send_tick(8'h03, 8'h01, 8'h02, 8'h03);

        // random phases, the last one without idling
        run_phase(470, 1'b1);
        run_phase(470, 1'b0);
        run_phase(470, 1'b1);
        run_phase(270, 1'b1);
        run_phase(200, 1'b0);

        // drain and let the block settle
        while (pending != 0)
            @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("alarm_table_time_matcher_top test passed");
        else
            $display("alarm_table_time_matcher_top test failed");
        $finish;
    end

endmodule

// ===== alarm_table_time_matcher_top.f =====
hdl/atm_pkg.sv
hdl/atm_ctrl.sv
hdl/atm_datapath.sv
hdl/alarm_table_time_matcher_top.sv
verif/alarm_table_time_matcher_checker.sv
verif/alarm_table_time_matcher_top_tb.sv
